// ----- rtl/debounced_button_note_emitter_macros.svh -----
// ---------------------------------------------------------------------------
// debounced button note emitter assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_NOTE_EMITTER_MACROS_SVH
`define DEBOUNCED_BUTTON_NOTE_EMITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DBNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbne same-cycle check failed");

// next-cycle implication, disabled during reset
`define DBNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbne next-cycle check failed");

`endif

// ----- rtl/dbne_pkg.sv -----
// ---------------------------------------------------------------------------
// dbne_pkg
// types, constants and field layout shared by the note emitter modules
// ---------------------------------------------------------------------------
package dbne_pkg;

  localparam int BUTTON_COUNT_DEF = 64;
  localparam int IN_DATA_W        = 64;
  localparam int OUT_DATA_W       = 24;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int ENTRY_W          = 6;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [6:0]  VELOCITY       = 7'h40;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] POL_PULL_DOWN     = 2'd0;
  localparam logic [1:0] POL_PULL_UP       = 2'd1;
  localparam logic [1:0] POL_INPUT_PULLUP  = 2'd2;

  localparam logic REG_DEBOUNCE = 1'b0;

  typedef struct packed {
    logic [1:0]  polarity;
    logic [7:0]  status;
    logic [6:0]  note;
    logic        stable;
    logic        raw;
    logic [31:0] change_time;
  } entry_t;

  typedef struct packed {
    logic        cmd;
    logic        level;
    logic [31:0] now_ms;
    logic [1:0]  polarity;
    logic [7:0]  msg_type;
    logic [3:0]  midi_chan;
    logic [6:0]  note;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] status;
    logic [6:0] note;
  } result_t;

endpackage

// ----- rtl/dbne_ram.sv -----
// ---------------------------------------------------------------------------
// dbne_ram
// entry table, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module dbne_ram #(
  parameter int DEPTH = dbne_pkg::BUTTON_COUNT_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  dbne_pkg::entry_t wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output dbne_pkg::entry_t rdata
);

  dbne_pkg::entry_t mem [DEPTH];
  dbne_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dbne_update.sv -----
// ---------------------------------------------------------------------------
// dbne_update
// next entry value and note result for one load or sample item
// ---------------------------------------------------------------------------
module dbne_update (
  input  dbne_pkg::item_t   item,
  input  dbne_pkg::entry_t  cur,
  input  logic [15:0]       debounce_ms,
  output dbne_pkg::entry_t  nxt,
  output dbne_pkg::result_t res
);

  logic        idle_lvl;
  logic [31:0] ct;
  logic [31:0] elapsed;
  logic        accept;
  logic        active;

  always_comb begin
    idle_lvl = (item.polarity == dbne_pkg::POL_PULL_UP) ||
               (item.polarity == dbne_pkg::POL_INPUT_PULLUP);
    ct       = (item.level != cur.raw) ? item.now_ms : cur.change_time;
    elapsed  = item.now_ms - ct;
    accept   = (elapsed > {16'd0, debounce_ms}) && (cur.stable != item.level);
    case (cur.polarity)
      dbne_pkg::POL_PULL_DOWN:    active = item.level;
      dbne_pkg::POL_PULL_UP:      active = !item.level;
      dbne_pkg::POL_INPUT_PULLUP: active = !item.level;
      default:                    active = 1'b0;
    endcase

    nxt        = cur;
    res.emit   = 1'b0;
    res.status = cur.status;
    res.note   = cur.note;
    if (item.cmd == dbne_pkg::CMD_LOAD) begin
      nxt.polarity    = item.polarity;
      nxt.status      = item.msg_type + {4'd0, item.midi_chan};
      nxt.note        = item.note;
      nxt.stable      = idle_lvl;
      nxt.raw         = idle_lvl;
      nxt.change_time = 32'd0;
    end else begin
      nxt.change_time = ct;
      nxt.raw         = item.level;
      if (accept) begin
        nxt.stable = item.level;
        res.emit   = active;
      end
    end
  end

endmodule

// ----- rtl/debounced_button_note_emitter.sv -----
// ---------------------------------------------------------------------------
// debounced_button_note_emitter
// per-button time debounce over an entry table, note message on press
// ---------------------------------------------------------------------------
//  channel  dir   handshake          contents
//  in_      in    tvalid/tready      tuser cmd, tdata entry and sample/load fields
//  out_     out   tvalid/tready      tdata status, note, velocity
//  cfg_     in    apb, pready high   debounce_ms at byte address 0
//
//  one item per cycle while the output is not stalled: table read at accept,
//  modify and write back in the update stage, a same-entry follower takes
//  the written value by bypass; result registered into one output register
//  a stalled output register holds the update stage and so the input
//  synchronous active-low reset clears control state, table is not cleared
// ---------------------------------------------------------------------------
module debounced_button_note_emitter #(
  parameter int BUTTON_COUNT = dbne_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] entry, [6] level, [38:7] now_ms, [40:39] polarity,
  // [48:41] msg_type, [52:49] midi_chan, [59:53] note
  input  logic [dbne_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] status_byte, [14:8] note_byte, [21:15] velocity_byte
  output logic [dbne_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [dbne_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dbne_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dbne_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int EXT_W = (IDX_W > dbne_pkg::ENTRY_W) ? IDX_W : dbne_pkg::ENTRY_W;

  logic [15:0]       debounce_r;
  dbne_pkg::item_t   in_item;
  logic [EXT_W-1:0]  entry_ext;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range;
  logic              in_acc;

  logic              s1_valid_r;
  dbne_pkg::item_t   s1_item_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_range_r;
  logic              fwd_hit_r;
  dbne_pkg::entry_t  fwd_data_r;
  logic              s1_go;
  logic              wr_en;

  dbne_pkg::entry_t  rd_data;
  dbne_pkg::entry_t  cur;
  dbne_pkg::entry_t  upd_nxt;
  dbne_pkg::result_t upd_res;

  logic              out_valid_r;
  logic [dbne_pkg::OUT_DATA_W-1:0] out_data_r;

  // config port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= dbne_pkg::DEBOUNCE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == dbne_pkg::REG_DEBOUNCE) begin
      debounce_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == dbne_pkg::REG_DEBOUNCE) ?
                      {16'd0, debounce_r} : '0;

  // input unpack
  always_comb begin
    in_item.cmd       = in_tuser;
    in_item.level     = in_tdata[6];
    in_item.now_ms    = in_tdata[38:7];
    in_item.polarity  = in_tdata[40:39];
    in_item.msg_type  = in_tdata[48:41];
    in_item.midi_chan = in_tdata[52:49];
    in_item.note      = in_tdata[59:53];
    entry_ext         = EXT_W'(in_tdata[5:0]);
    in_idx            = entry_ext[IDX_W-1:0];
    in_range          = 32'(in_tdata[5:0]) < BUTTON_COUNT;
  end

  assign s1_go     = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = s1_valid_r && s1_go && s1_range_r;

  dbne_ram #(
    .DEPTH (BUTTON_COUNT),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx_r),
    .wdata (upd_nxt),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (rd_data)
  );

  assign cur = fwd_hit_r ? fwd_data_r : rd_data;

  dbne_update u_update (
    .item        (s1_item_r),
    .cur         (cur),
    .debounce_ms (debounce_r),
    .nxt         (upd_nxt),
    .res         (upd_res)
  );

  // update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r  <= in_item;
      s1_idx_r   <= in_idx;
      s1_range_r <= in_range;
      fwd_hit_r  <= wr_en && (s1_idx_r == in_idx);
      fwd_data_r <= upd_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_en && upd_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && upd_res.emit) begin
      out_data_r <= {2'b00, dbne_pkg::VELOCITY, upd_res.note, upd_res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/dbne_checker.sv -----
// ---------------------------------------------------------------------------
// dbne_checker
// port-level checks on the note emitter, bound to the top level
// ---------------------------------------------------------------------------
`include "debounced_button_note_emitter_macros.svh"

module dbne_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [dbne_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dbne_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic [dbne_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input logic [dbne_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input logic [dbne_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input logic                            cfg_pready
);

  `DBNE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `DBNE_ASSERT_NOW(a_velocity, clk, rst_n, out_tvalid, out_tdata[21:15] == dbne_pkg::VELOCITY)
  `DBNE_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[23:22] == 2'b00)
  `DBNE_ASSERT_NOW(a_ready_free, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind debounced_button_note_emitter dbne_checker u_dbne_checker (.*);
